[rtl/hitw_pkg.sv]
// Package: types and constants shared by the heater idle timeout watchdog.
`default_nettype none
package hitw_pkg;

  localparam int unsigned TEMP_W = 12;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [TEMP_W-1:0] HOTEND_TRIGGER_RST = 12'd720;
  localparam logic [TEMP_W-1:0] BED_TRIGGER_RST    = 12'd200;
  localparam logic [WORD_W-1:0] INTERVAL_MS_RST    = 32'd300000;
  localparam logic [TEMP_W-1:0] NOZZLE_IDLE_RST    = 12'd0;
  localparam logic [TEMP_W-1:0] BED_IDLE_RST       = 12'd0;

  typedef enum logic [2:0] {
    REG_HOTEND_TRIGGER = 3'd0,
    REG_BED_TRIGGER    = 3'd1,
    REG_INTERVAL_MS    = 3'd2,
    REG_NOZZLE_IDLE    = 3'd3,
    REG_BED_IDLE       = 3'd4,
    REG_XYZ_ENABLE     = 3'd5
  } hitw_reg_t;

  typedef struct packed {
    logic [WORD_W-1:0] now_ms;
    logic              busy_req;
    logic [TEMP_W-1:0] hotend_temp;
    logic [TEMP_W-1:0] bed_temp;
    logic [WORD_W-1:0] e_position;
    logic [WORD_W-1:0] x_position;
    logic [WORD_W-1:0] y_position;
    logic [WORD_W-1:0] z_position;
    logic [WORD_W-1:0] click_count;
    logic              critical_section;
    logic [TEMP_W-1:0] hotend_target;
    logic [TEMP_W-1:0] bed_target;
  } hitw_in_t;

  typedef struct packed {
    logic              idle_fired;
    logic [TEMP_W-1:0] new_hotend_target;
    logic [TEMP_W-1:0] new_bed_target;
    logic              armed;
  } hitw_out_t;

  typedef struct packed {
    logic [TEMP_W-1:0] hotend_trigger;
    logic [TEMP_W-1:0] bed_trigger;
    logic [WORD_W-1:0] interval_ms;
    logic [TEMP_W-1:0] nozzle_idle_target;
    logic [TEMP_W-1:0] bed_idle_target;
    logic              xyz_enable;
  } hitw_cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] deadline;
    logic [WORD_W-1:0] last_e_word;
    logic [WORD_W-1:0] last_x_word;
    logic [WORD_W-1:0] last_y_word;
    logic [WORD_W-1:0] last_z_word;
    logic [WORD_W-1:0] last_clicks;
  } hitw_state_t;

endpackage
`default_nettype wire

[rtl/heater_idle_timeout_watchdog.sv]
// Top level: heater idle timeout watchdog with register port and item pipeline.
// Pipeline: input register, then result register; a held result can stall the item between them.
// Throughput: one item per cycle while each result is taken; a held result stops the flow.
// Stall: a held result still lets one more item wait in the input register.
// Reset: synchronous, active low; registers return to defaults, deadline disarmed,
// tracked words cleared, both pipeline stages empty.
`default_nettype none
module heater_idle_timeout_watchdog
  import hitw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire hitw_in_t          in_data,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      hitw_out_t         out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [DATA_W-1:0] cfg_pwdata,
  output      logic [DATA_W-1:0] cfg_prdata,
  output      logic              cfg_pready
);

  hitw_cfg_t   cfg_r;
  hitw_state_t st_r;
  hitw_state_t st_nxt;
  hitw_in_t    item_r;
  logic        item_v_r;
  hitw_out_t   res_nxt;
  hitw_out_t   res_r;
  logic        res_v_r;
  logic        advance;
  logic        cfg_wr;
  hitw_reg_t   cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = hitw_reg_t'(cfg_paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hotend_trigger     <= HOTEND_TRIGGER_RST;
      cfg_r.bed_trigger        <= BED_TRIGGER_RST;
      cfg_r.interval_ms        <= INTERVAL_MS_RST;
      cfg_r.nozzle_idle_target <= NOZZLE_IDLE_RST;
      cfg_r.bed_idle_target    <= BED_IDLE_RST;
      cfg_r.xyz_enable         <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HOTEND_TRIGGER: cfg_r.hotend_trigger     <= cfg_pwdata[TEMP_W-1:0];
        REG_BED_TRIGGER:    cfg_r.bed_trigger        <= cfg_pwdata[TEMP_W-1:0];
        REG_INTERVAL_MS:    cfg_r.interval_ms        <= cfg_pwdata[WORD_W-1:0];
        REG_NOZZLE_IDLE:    cfg_r.nozzle_idle_target <= cfg_pwdata[TEMP_W-1:0];
        REG_BED_IDLE:       cfg_r.bed_idle_target    <= cfg_pwdata[TEMP_W-1:0];
        REG_XYZ_ENABLE:     cfg_r.xyz_enable         <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HOTEND_TRIGGER: cfg_prdata = DATA_W'(cfg_r.hotend_trigger);
      REG_BED_TRIGGER:    cfg_prdata = DATA_W'(cfg_r.bed_trigger);
      REG_INTERVAL_MS:    cfg_prdata = DATA_W'(cfg_r.interval_ms);
      REG_NOZZLE_IDLE:    cfg_prdata = DATA_W'(cfg_r.nozzle_idle_target);
      REG_BED_IDLE:       cfg_prdata = DATA_W'(cfg_r.bed_idle_target);
      REG_XYZ_ENABLE:     cfg_prdata = DATA_W'(cfg_r.xyz_enable);
      default:            cfg_prdata = '0;
    endcase
  end

  assign advance  = item_v_r && (!res_v_r || out_ready);
  assign in_ready = !item_v_r || advance;

  hitw_core u_core (
    .item (item_r),
    .cfg  (cfg_r),
    .cur  (st_r),
    .nxt  (st_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      res_v_r  <= 1'b0;
      st_r     <= '0;
    end else begin
      if (in_ready) begin
        item_v_r <= in_valid;
      end
      if (advance) begin
        res_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (out_ready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_v_r;
  assign out_data  = res_r;

endmodule
`default_nettype wire

[rtl/hitw_core.sv]
// Tick logic: arm, postpone and expiry decision for one item.
`default_nettype none
module hitw_core
  import hitw_pkg::*;
(
  input  hitw_in_t    item,
  input  hitw_cfg_t   cfg,
  input  hitw_state_t cur,
  output hitw_state_t nxt,
  output hitw_out_t   res
);

  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] lag;
  logic [WORD_W-1:0] neg_interval;
  logic [WORD_W-1:0] d1;
  logic [WORD_W-1:0] d2;
  logic              armed_prev;
  logic              protect;
  logic              d1_from_sum;
  logic              moved;
  logic              post;
  logic              from_sum;
  logic              expire;

  always_comb begin
    sum          = item.now_ms + cfg.interval_ms;
    lag          = item.now_ms - cur.deadline;
    neg_interval = '0 - cfg.interval_ms;
    armed_prev   = (cur.deadline != '0);
    protect      = !item.busy_req &&
                   ((item.hotend_temp >= cfg.hotend_trigger) ||
                    (item.bed_temp >= cfg.bed_trigger));

    d1_from_sum = 1'b0;
    d1          = cur.deadline;
    if (armed_prev != protect) begin
      d1_from_sum = protect;
      d1          = protect ? sum : '0;
    end

    moved = (cur.last_e_word != item.e_position) ||
            (cur.last_clicks != item.click_count) ||
            item.critical_section ||
            (cfg.xyz_enable &&
             ((cur.last_x_word != item.x_position) ||
              (cur.last_y_word != item.y_position) ||
              (cur.last_z_word != item.z_position)));
    post     = moved && (d1 != '0);
    d2       = post ? sum : d1;
    from_sum = post || d1_from_sum;
    // past deadline when now - deadline lands in the lower half
    expire   = (d2 != '0) && (from_sum ? !neg_interval[WORD_W-1] : !lag[WORD_W-1]);

    nxt.deadline    = expire ? '0 : d2;
    nxt.last_e_word = item.e_position;
    nxt.last_clicks = item.click_count;
    nxt.last_x_word = cfg.xyz_enable ? item.x_position : cur.last_x_word;
    nxt.last_y_word = cfg.xyz_enable ? item.y_position : cur.last_y_word;
    nxt.last_z_word = cfg.xyz_enable ? item.z_position : cur.last_z_word;

    res.idle_fired        = expire;
    res.new_hotend_target = (expire && (cfg.nozzle_idle_target < item.hotend_target)) ?
                            cfg.nozzle_idle_target : item.hotend_target;
    res.new_bed_target    = (expire && (cfg.bed_idle_target < item.bed_target)) ?
                            cfg.bed_idle_target : item.bed_target;
    res.armed             = !expire && (d2 != '0);
  end

endmodule
`default_nettype wire

[rtl/hitw_checker.sv]
// Checker: port-level assertions for the watchdog, attached by bind.
`default_nettype none
module hitw_checker
  import hitw_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire hitw_out_t out_data,
  input wire logic      cfg_pready
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.idle_fired |-> !out_data.armed)
    else $error("timeout reported while still armed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("register port stalled");

endmodule

bind heater_idle_timeout_watchdog hitw_checker u_hitw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_data   (out_data),
  .cfg_pready (cfg_pready)
);
`default_nettype wire
